/* rtl/wpf_pkg.sv */
// Shared types, constants and stage positions of the WCA pair force pipeline.
package wpf_pkg;

  // Field widths
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned FRAC_BITS = 16;

  // Internal arithmetic widths
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned HALF_W    = ACC_W / 2;
  localparam int unsigned LOW_IDX_W = $clog2(HALF_W);
  localparam int unsigned MAG_W     = POS_W + 1;
  localparam int unsigned SQ_W      = 2 * POS_W + 1;
  localparam int unsigned AXES      = 3;

  // Divider: quotient bits resolved per stage
  localparam int unsigned DIV_STAGES = 32;
  localparam int unsigned DIV_STEPS  = ACC_W / DIV_STAGES;

  // Stage positions of the context line (unit results line up with these)
  localparam int unsigned K_R2  = 2;
  localparam int unsigned K_DIV = K_R2 + DIV_STAGES;
  localparam int unsigned K_A   = K_DIV + 2;
  localparam int unsigned K_B   = K_A + 2;
  localparam int unsigned K_C   = K_B + 2;
  localparam int unsigned K_T   = K_C + 1;
  localparam int unsigned K_D   = K_T + 2;
  localparam int unsigned K_F   = K_D + 1;
  localparam int unsigned K_E   = K_F + 2;
  localparam int unsigned K_O   = K_E + 1;
  localparam int unsigned NST   = K_O + 1;

  // Register reset values
  localparam logic [CFG_W-1:0] SIGMA_RESET  = 32'd65536;
  localparam logic [CFG_W-1:0] CUTOFF_RESET = 32'd82570;
  localparam logic [CFG_W-1:0] EPS_RESET    = 32'd1572864;

  // Full-scale component limits
  localparam logic [POS_W-1:0] LIM_POS = 32'h7FFF_FFFF;
  localparam logic [POS_W-1:0] LIM_NEG = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIGMA_SQUARE  = 2'd0,
    CFG_CUTOFF_SQUARE = 2'd1,
    CFG_EPSILON_X24   = 2'd2
  } cfg_reg_e;

  // Everything an item carries down the pipeline
  typedef struct packed {
    logic [IDX_W-1:0]           first_index;
    logic [IDX_W-1:0]           second_index;
    logic [AXES-1:0]            dneg;
    logic [AXES-1:0][MAG_W-1:0] mag;
    logic [AXES-1:0][SQ_W-1:0]  sq;
    logic [ACC_W-1:0]           r2;
    logic                       coin;
    logic                       live;
    logic [ACC_W-1:0]           q;
    logic [ACC_W-1:0]           e;
    logic [ACC_W-1:0]           s;
    logic [ACC_W-1:0]           m;
    logic [ACC_W-1:0]           f;
    logic                       big;
    logic                       eo;
    logic                       neg;
    logic                       fzero;
    logic                       fsat;
    logic [AXES-1:0][POS_W-1:0] frc;
    logic                       in_range;
    logic                       sat;
  } wpf_ctx_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_first_index;
    logic [IDX_W-1:0]        out_second_index;
    logic signed [POS_W-1:0] force_x;
    logic signed [POS_W-1:0] force_y;
    logic signed [POS_W-1:0] force_z;
    logic                    in_range;
    logic                    saturated;
    logic                    coincident;
  } wpf_res_t;

endpackage

/* rtl/wpf_ifs.sv */
// Channel interfaces: pair input, force result and register write.

interface wpf_in_if;
  logic                              valid;
  logic                              ready;
  logic [wpf_pkg::IDX_W-1:0]         first_index;
  logic [wpf_pkg::IDX_W-1:0]         second_index;
  logic signed [wpf_pkg::POS_W-1:0]  first_x;
  logic signed [wpf_pkg::POS_W-1:0]  first_y;
  logic signed [wpf_pkg::POS_W-1:0]  first_z;
  logic signed [wpf_pkg::POS_W-1:0]  second_x;
  logic signed [wpf_pkg::POS_W-1:0]  second_y;
  logic signed [wpf_pkg::POS_W-1:0]  second_z;

  modport source (output valid, first_index, second_index, first_x, first_y, first_z,
                  second_x, second_y, second_z, input ready);
  modport sink (input valid, first_index, second_index, first_x, first_y, first_z,
                second_x, second_y, second_z, output ready);
endinterface

interface wpf_out_if;
  logic                              valid;
  logic                              ready;
  logic [wpf_pkg::IDX_W-1:0]         out_first_index;
  logic [wpf_pkg::IDX_W-1:0]         out_second_index;
  logic signed [wpf_pkg::POS_W-1:0]  force_x;
  logic signed [wpf_pkg::POS_W-1:0]  force_y;
  logic signed [wpf_pkg::POS_W-1:0]  force_z;
  logic                              in_range;
  logic                              saturated;
  logic                              coincident;

  modport source (output valid, out_first_index, out_second_index, force_x, force_y,
                  force_z, in_range, saturated, coincident, input ready);
  modport sink (input valid, out_first_index, out_second_index, force_x, force_y,
                force_z, in_range, saturated, coincident, output ready);
endinterface

interface wpf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wpf_pkg::CFG_IDX_W-1:0] index;
  logic [wpf_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/wpf_div.sv */
// Pipelined restoring divider: floor(a * 2^32 / b), saturating, fixed quotient bits per stage.
module wpf_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [wpf_pkg::ACC_W-1:0] dividend_i,
  input  logic [wpf_pkg::ACC_W-1:0] divisor_i,
  output logic [wpf_pkg::ACC_W-1:0] quot_o,
  output logic                      ovf_o
);

  logic [wpf_pkg::ACC_W-1:0]  rem_q [wpf_pkg::DIV_STAGES];
  logic [wpf_pkg::ACC_W-1:0]  quo_q [wpf_pkg::DIV_STAGES];
  logic [wpf_pkg::ACC_W-1:0]  dvs_q [wpf_pkg::DIV_STAGES];
  logic [wpf_pkg::HALF_W-1:0] low_q [wpf_pkg::DIV_STAGES];
  logic                       ovf_q [wpf_pkg::DIV_STAGES];

  logic [wpf_pkg::ACC_W-1:0]  rem_d [wpf_pkg::DIV_STAGES];
  logic [wpf_pkg::ACC_W-1:0]  quo_d [wpf_pkg::DIV_STAGES];
  logic [wpf_pkg::ACC_W-1:0]  dvs_d [wpf_pkg::DIV_STAGES];
  logic [wpf_pkg::HALF_W-1:0] low_d [wpf_pkg::DIV_STAGES];
  logic                       ovf_d [wpf_pkg::DIV_STAGES];

  // Each stage shifts in DIV_STEPS dividend bits and resolves as many quotient bits
  always_comb begin
    logic [wpf_pkg::ACC_W-1:0]  rem;
    logic [wpf_pkg::ACC_W-1:0]  quo;
    logic [wpf_pkg::ACC_W-1:0]  dvs;
    logic [wpf_pkg::HALF_W-1:0] low;
    logic                       ovf;
    logic [wpf_pkg::ACC_W:0]    rsh;
    logic                       nbit;
    logic                       ge;
    int                         idx;
    for (int k = 0; k < wpf_pkg::DIV_STAGES; k++) begin
      if (k == 0) begin
        rem = {{wpf_pkg::HALF_W{1'b0}}, dividend_i[wpf_pkg::ACC_W-1:wpf_pkg::HALF_W]};
        low = dividend_i[wpf_pkg::HALF_W-1:0];
        dvs = divisor_i;
        quo = '0;
        ovf = (divisor_i == '0) || (rem >= divisor_i);
      end else begin
        rem = rem_q[k-1];
        low = low_q[k-1];
        dvs = dvs_q[k-1];
        quo = quo_q[k-1];
        ovf = ovf_q[k-1];
      end
      for (int j = 0; j < wpf_pkg::DIV_STEPS; j++) begin
        idx  = wpf_pkg::ACC_W - 1 - k * wpf_pkg::DIV_STEPS - j;
        nbit = (idx >= wpf_pkg::HALF_W) ?
               low[wpf_pkg::LOW_IDX_W'(idx - wpf_pkg::HALF_W)] : 1'b0;
        rsh  = {rem, nbit};
        ge   = (rsh >= {1'b0, dvs});
        rem  = ge ? wpf_pkg::ACC_W'(rsh - {1'b0, dvs}) : rsh[wpf_pkg::ACC_W-1:0];
        quo  = {quo[wpf_pkg::ACC_W-2:0], ge};
      end
      rem_d[k] = rem;
      quo_d[k] = quo;
      dvs_d[k] = dvs;
      low_d[k] = low;
      ovf_d[k] = ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < wpf_pkg::DIV_STAGES; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        dvs_q[k] <= dvs_d[k];
        low_q[k] <= low_d[k];
        ovf_q[k] <= ovf_d[k];
      end
    end
  end

  // Saturated quotient reads as all ones
  assign ovf_o  = ovf_q[wpf_pkg::DIV_STAGES-1];
  assign quot_o = ovf_o ? '1 : quo_q[wpf_pkg::DIV_STAGES-1];

endmodule

/* rtl/wpf_mulq.sv */
// Two-stage saturating Q32.32 multiplier: floor(a * b / 2^32) from four 32x32 products.
module wpf_mulq (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [wpf_pkg::ACC_W-1:0] a_i,
  input  logic [wpf_pkg::ACC_W-1:0] b_i,
  output logic [wpf_pkg::ACC_W-1:0] prod_o,
  output logic                      ovf_o
);

  localparam int unsigned W = wpf_pkg::ACC_W;
  localparam int unsigned H = wpf_pkg::HALF_W;

  logic [W-1:0] hh_q, hl_q, lh_q, ll_q;
  logic [W-1:0] prod_q, prod_d;
  logic         ovf_q, ovf_d;
  logic [W+1:0] sum;

  // Partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q <= W'(a_i[W-1:H]) * W'(b_i[W-1:H]);
      hl_q <= W'(a_i[W-1:H]) * W'(b_i[H-1:0]);
      lh_q <= W'(a_i[H-1:0]) * W'(b_i[W-1:H]);
      ll_q <= W'(a_i[H-1:0]) * W'(b_i[H-1:0]);
    end
  end

  // Align, sum and clip
  always_comb begin
    sum    = {2'b00, hh_q[H-1:0], {H{1'b0}}} + {2'b00, hl_q} + {2'b00, lh_q}
           + {{(H+2){1'b0}}, ll_q[W-1:H]};
    ovf_d  = (|hh_q[W-1:H]) || (|sum[W+1:W]);
    prod_d = ovf_d ? '1 : sum[W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      ovf_q  <= ovf_d;
    end
  end

  assign prod_o = prod_q;
  assign ovf_o  = ovf_q;

endmodule

/* rtl/wca_pair_force_core.sv */
// WCA pair force pipeline: top level with stage line, units, registers and output skid.
//
//  Channel | Dir | Handshake          | Beat
//  pair_i  | in  | valid / ready      | two indices, two 3D Q15.16 positions
//  res_o   | out | valid / ready      | indices, Q15.16 force, range/clip/coincident flags
//  cfg_i   | in  | valid / ready (=1) | register index, 32-bit value
//
// One pair per cycle while res_o takes results; each result leaves through the output register.
// Depth comes from the 64-bit restoring divider (2 quotient bits per stage) and
// the chain of 64-bit multiplies, each split over two stages.
// Reset clears the stage valid bits and the output and skid valid flags and loads the register defaults.
// A stalled result sits in the output register; one more beat lands in the skid,
// then pair_i.ready drops and the whole line holds.
module wca_pair_force_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  wpf_in_if.sink      pair_i,
  wpf_out_if.source   res_o,
  wpf_cfg_if.sink     cfg_i
);

  localparam int unsigned NST = wpf_pkg::NST;
  localparam int unsigned W   = wpf_pkg::ACC_W;

  logic [wpf_pkg::CFG_W-1:0] sigma_q, cutoff_q, eps_q;

  wpf_pkg::wpf_ctx_t ctx_q [NST];
  wpf_pkg::wpf_ctx_t ctx_d [NST];
  logic [NST-1:0]    vld_q;
  logic              adv;

  wpf_pkg::wpf_res_t pipe_res, res_q, skid_q;
  logic              res_vld_q, skid_vld_q;

  logic [W-1:0] dq, de, pa, pb, pc, pd;
  logic         dq_ovf, de_ovf, oa, ob, oc, od;
  logic [W-1:0] pe [wpf_pkg::AXES];
  logic         oe [wpf_pkg::AXES];

  // Register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q  <= wpf_pkg::SIGMA_RESET;
      cutoff_q <= wpf_pkg::CUTOFF_RESET;
      eps_q    <= wpf_pkg::EPS_RESET;
    end else if (cfg_i.valid) begin
      case (wpf_pkg::cfg_reg_e'(cfg_i.index))
        wpf_pkg::CFG_SIGMA_SQUARE:  sigma_q  <= cfg_i.data;
        wpf_pkg::CFG_CUTOFF_SQUARE: cutoff_q <= cfg_i.data;
        wpf_pkg::CFG_EPSILON_X24:   eps_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Line advances while the skid is free
  assign adv          = !skid_vld_q;
  assign pair_i.ready = adv;

  // Arithmetic units
  wpf_div u_div_q (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i ({{(W-wpf_pkg::CFG_W-wpf_pkg::FRAC_BITS){1'b0}}, sigma_q,
                  {wpf_pkg::FRAC_BITS{1'b0}}}),
    .divisor_i  (ctx_q[wpf_pkg::K_R2].r2),
    .quot_o     (dq),
    .ovf_o      (dq_ovf)
  );

  wpf_div u_div_e (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i ({{(W-wpf_pkg::CFG_W-wpf_pkg::FRAC_BITS){1'b0}}, eps_q,
                  {wpf_pkg::FRAC_BITS{1'b0}}}),
    .divisor_i  (ctx_q[wpf_pkg::K_R2].r2),
    .quot_o     (de),
    .ovf_o      (de_ovf)
  );

  // q^2
  wpf_mulq u_mul_a (.clk_i(clk_i), .en_i(adv), .a_i(dq), .b_i(dq), .prod_o(pa), .ovf_o(oa));
  // s = q^3
  wpf_mulq u_mul_b (.clk_i(clk_i), .en_i(adv), .a_i(pa), .b_i(ctx_q[wpf_pkg::K_A].q),
                    .prod_o(pb), .ovf_o(ob));
  // s^2
  wpf_mulq u_mul_c (.clk_i(clk_i), .en_i(adv), .a_i(pb), .b_i(pb), .prod_o(pc), .ovf_o(oc));
  // f = e * m
  wpf_mulq u_mul_d (.clk_i(clk_i), .en_i(adv), .a_i(ctx_q[wpf_pkg::K_T].e),
                    .b_i(ctx_q[wpf_pkg::K_T].m), .prod_o(pd), .ovf_o(od));

  // Per-axis |d| * f
  for (genvar c = 0; c < wpf_pkg::AXES; c++) begin : g_axis
    wpf_mulq u_mul_e (
      .clk_i  (clk_i),
      .en_i   (adv),
      .a_i    ({{(W-wpf_pkg::MAG_W){1'b0}}, ctx_q[wpf_pkg::K_F].mag[c]}),
      .b_i    (ctx_q[wpf_pkg::K_F].f),
      .prod_o (pe[c]),
      .ovf_o  (oe[c])
    );
  end

  // Stage logic
  always_comb begin
    logic [wpf_pkg::POS_W-1:0] pos_a [wpf_pkg::AXES];
    logic [wpf_pkg::POS_W-1:0] pos_b [wpf_pkg::AXES];
    logic [wpf_pkg::MAG_W-1:0] dif;
    logic [2*wpf_pkg::MAG_W-1:0] sqw;
    logic [W+2:0]              sum;
    logic [W-1:0]              r2;
    logic [W-1:0]              s2, t, s;
    logic                      big;
    logic                      nc, satv, anyv;
    logic [wpf_pkg::POS_W-1:0] lim, p;

    pos_a[0] = pair_i.first_x;
    pos_a[1] = pair_i.first_y;
    pos_a[2] = pair_i.first_z;
    pos_b[0] = pair_i.second_x;
    pos_b[1] = pair_i.second_y;
    pos_b[2] = pair_i.second_z;

    // Entry: difference vector as sign and magnitude
    ctx_d[0] = '0;
    ctx_d[0].first_index  = pair_i.first_index;
    ctx_d[0].second_index = pair_i.second_index;
    for (int c = 0; c < wpf_pkg::AXES; c++) begin
      dif = {pos_b[c][wpf_pkg::POS_W-1], pos_b[c]} - {pos_a[c][wpf_pkg::POS_W-1], pos_a[c]};
      ctx_d[0].dneg[c] = dif[wpf_pkg::MAG_W-1];
      ctx_d[0].mag[c]  = dif[wpf_pkg::MAG_W-1] ? wpf_pkg::MAG_W'(-dif) : dif;
    end

    for (int k = 1; k < NST; k++) begin
      ctx_d[k] = ctx_q[k-1];
    end

    // Squares
    for (int c = 0; c < wpf_pkg::AXES; c++) begin
      sqw = {{wpf_pkg::MAG_W{1'b0}}, ctx_q[0].mag[c]} * {{wpf_pkg::MAG_W{1'b0}}, ctx_q[0].mag[c]};
      ctx_d[1].sq[c] = sqw[wpf_pkg::SQ_W-1:0];
    end

    // r2, coincidence and cutoff
    sum = (W+3)'(ctx_q[1].sq[0]) + (W+3)'(ctx_q[1].sq[1]) + (W+3)'(ctx_q[1].sq[2]);
    r2  = (|sum[W+2:W]) ? '1 : sum[W-1:0];
    ctx_d[wpf_pkg::K_R2].r2   = r2;
    ctx_d[wpf_pkg::K_R2].coin = (r2 == '0);
    ctx_d[wpf_pkg::K_R2].live = (r2 != '0) &&
      (r2 < {{(W-wpf_pkg::CFG_W-wpf_pkg::FRAC_BITS){1'b0}}, cutoff_q,
             {wpf_pkg::FRAC_BITS{1'b0}}});

    // Quotients in
    ctx_d[wpf_pkg::K_DIV+1].q   = dq;
    ctx_d[wpf_pkg::K_DIV+1].big = dq_ovf;
    ctx_d[wpf_pkg::K_DIV+1].e   = de;
    ctx_d[wpf_pkg::K_DIV+1].eo  = de_ovf;

    ctx_d[wpf_pkg::K_A+1].big = ctx_q[wpf_pkg::K_A].big | oa;
    ctx_d[wpf_pkg::K_B+1].big = ctx_q[wpf_pkg::K_B].big | ob;
    ctx_d[wpf_pkg::K_B+1].s   = pb;

    // m = |s - 2 s^2| and its sign
    s2  = pc;
    s   = ctx_q[wpf_pkg::K_C].s;
    big = ctx_q[wpf_pkg::K_C].big | oc | s2[W-1];
    t   = {s2[W-2:0], 1'b0};
    ctx_d[wpf_pkg::K_T].big = big;
    if (big) begin
      ctx_d[wpf_pkg::K_T].m   = '1;
      ctx_d[wpf_pkg::K_T].neg = 1'b1;
    end else begin
      ctx_d[wpf_pkg::K_T].neg = (t > s);
      ctx_d[wpf_pkg::K_T].m   = (t > s) ? (t - s) : (s - t);
    end

    // Scalar f
    ctx_d[wpf_pkg::K_F].fzero = (ctx_q[wpf_pkg::K_D].m == '0) || (ctx_q[wpf_pkg::K_D].e == '0);
    ctx_d[wpf_pkg::K_F].fsat  = !ctx_d[wpf_pkg::K_F].fzero &&
      (ctx_q[wpf_pkg::K_D].eo || ctx_q[wpf_pkg::K_D].big || od);
    ctx_d[wpf_pkg::K_F].f     = ctx_d[wpf_pkg::K_F].fzero ? '0 : pd;

    // Components: clip, sign, flags
    satv = 1'b0;
    anyv = 1'b0;
    for (int c = 0; c < wpf_pkg::AXES; c++) begin
      nc  = ctx_q[wpf_pkg::K_E].dneg[c] ^ ctx_q[wpf_pkg::K_E].neg;
      lim = nc ? wpf_pkg::LIM_NEG : wpf_pkg::LIM_POS;
      p   = '0;
      if (ctx_q[wpf_pkg::K_E].mag[c] != '0) begin
        if (ctx_q[wpf_pkg::K_E].fsat || oe[c] ||
            (pe[c] > {{(W-wpf_pkg::POS_W){1'b0}}, lim})) begin
          p    = lim;
          satv = 1'b1;
        end else begin
          p = pe[c][wpf_pkg::POS_W-1:0];
        end
      end
      if (p != '0) begin
        anyv = 1'b1;
      end
      ctx_d[wpf_pkg::K_O].frc[c] = (ctx_q[wpf_pkg::K_E].live) ? (nc ? (-p) : p) : '0;
    end
    ctx_d[wpf_pkg::K_O].in_range = ctx_q[wpf_pkg::K_E].live && anyv;
    ctx_d[wpf_pkg::K_O].sat      = ctx_q[wpf_pkg::K_E].live && satv;
  end

  // Stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], pair_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) begin
        ctx_q[k] <= ctx_d[k];
      end
    end
  end

  // Result of the last stage
  always_comb begin
    pipe_res.out_first_index  = ctx_q[wpf_pkg::K_O].first_index;
    pipe_res.out_second_index = ctx_q[wpf_pkg::K_O].second_index;
    pipe_res.force_x          = ctx_q[wpf_pkg::K_O].frc[0];
    pipe_res.force_y          = ctx_q[wpf_pkg::K_O].frc[1];
    pipe_res.force_z          = ctx_q[wpf_pkg::K_O].frc[2];
    pipe_res.in_range         = ctx_q[wpf_pkg::K_O].in_range;
    pipe_res.saturated        = ctx_q[wpf_pkg::K_O].sat;
    pipe_res.coincident       = ctx_q[wpf_pkg::K_O].coin;
  end

  // Output register and skid: control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!res_vld_q || res_o.ready) begin
      if (skid_vld_q) begin
        res_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        res_vld_q <= vld_q[wpf_pkg::K_O];
      end
    end else if (adv && vld_q[wpf_pkg::K_O]) begin
      skid_vld_q <= 1'b1;
    end
  end

  // Output register and skid: payload
  always_ff @(posedge clk_i) begin
    if (!res_vld_q || res_o.ready) begin
      res_q <= skid_vld_q ? skid_q : pipe_res;
    end else if (adv) begin
      skid_q <= pipe_res;
    end
  end

  assign res_o.valid            = res_vld_q;
  assign res_o.out_first_index  = res_q.out_first_index;
  assign res_o.out_second_index = res_q.out_second_index;
  assign res_o.force_x          = res_q.force_x;
  assign res_o.force_y          = res_q.force_y;
  assign res_o.force_z          = res_q.force_z;
  assign res_o.in_range         = res_q.in_range;
  assign res_o.saturated        = res_q.saturated;
  assign res_o.coincident       = res_q.coincident;

endmodule

/* rtl/wpf_chk.sv */
// Port-level checks on the result channel of the pair force core, with its bind.
module wpf_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       res_valid_i,
  input logic                       res_ready_i,
  input logic [wpf_pkg::POS_W-1:0]  force_x_i,
  input logic [wpf_pkg::POS_W-1:0]  force_y_i,
  input logic [wpf_pkg::POS_W-1:0]  force_z_i,
  input logic                       in_range_i,
  input logic                       saturated_i,
  input logic                       coincident_i
);

  // A stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(force_x_i) &&
    $stable(force_y_i) && $stable(force_z_i))
    else $error("result changed while stalled");

  // Coincident pairs give no force and no other flag
  a_coin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && coincident_i |-> force_x_i == '0 && force_y_i == '0 &&
    force_z_i == '0 && !in_range_i && !saturated_i)
    else $error("coincident pair with force or flags");

  // Out of range means zero force and no clipping
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !in_range_i |-> force_x_i == '0 && force_y_i == '0 &&
    force_z_i == '0 && !saturated_i)
    else $error("force outside range");

  // Clipping shows as a full-scale component
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && saturated_i |->
      force_x_i == wpf_pkg::LIM_POS || force_x_i == wpf_pkg::LIM_NEG ||
      force_y_i == wpf_pkg::LIM_POS || force_y_i == wpf_pkg::LIM_NEG ||
      force_z_i == wpf_pkg::LIM_POS || force_z_i == wpf_pkg::LIM_NEG)
    else $error("saturated without a full-scale component");

endmodule

bind wca_pair_force_core wpf_chk u_wpf_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .force_x_i    (res_o.force_x),
  .force_y_i    (res_o.force_y),
  .force_z_i    (res_o.force_z),
  .in_range_i   (res_o.in_range),
  .saturated_i  (res_o.saturated),
  .coincident_i (res_o.coincident)
);

/* tb/sv/tb.sv */
// Testbench for the WCA pair force pipeline: table-driven directed pairs, random pairs, predictor check.
module tb;

  localparam int unsigned LATENCY = 48;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  wpf_in_if  pair_if ();
  wpf_out_if res_if ();
  wpf_cfg_if cfg_if ();

  wca_pair_force_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pair_i(pair_if.sink),
    .res_o (res_if.source),
    .cfg_i (cfg_if.sink)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  typedef struct {
    logic [wpf_pkg::IDX_W-1:0]        fi;
    logic [wpf_pkg::IDX_W-1:0]        si;
    logic signed [wpf_pkg::POS_W-1:0] p [6];
  } pair_t;

  // Directed row: pair, plus a typed-in result where it is obvious
  typedef struct {
    pair_t             pr;
    logic              known;
    wpf_pkg::wpf_res_t res;
  } row_t;

  // Register copies for the predictor
  logic [63:0]       sig_sq, cut_sq, eps24;
  wpf_pkg::wpf_res_t force_q [$];
  int                errors = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;

  // floor(a*b/2^32) with saturation
  function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b,
                                          inout logic ovf);
    logic [127:0] p;
    p = a * b;
    p = p >> 32;
    if (p[127:64] != 0) begin
      ovf = 1'b1;
      return '1;
    end
    return p[63:0];
  endfunction

  // floor(a*2^32/b) with saturation
  function automatic logic [63:0] div_q32(input logic [63:0] a, input logic [63:0] b,
                                          inout logic ovf);
    logic [127:0] n, q;
    if (b == 0 || (a >> 32) >= b) begin
      ovf = 1'b1;
      return '1;
    end
    n = {a, 32'b0};
    q = n / b;
    return q[63:0];
  endfunction

  function automatic wpf_pkg::wpf_res_t pair_force(input pair_t pr);
    wpf_pkg::wpf_res_t r;
    logic signed [33:0] d [3];
    logic [63:0] mag [3];
    logic [63:0] comp [3];
    logic [65:0] r2w;
    logic [63:0] r2, q, q2, s, s2, t, m, e, f, lim, p;
    logic big, eo, fsat, neg, nc, po, sat, any;
    r = '0;
    r.out_first_index = pr.fi;
    r.out_second_index = pr.si;
    r2w = 0;
    for (int c = 0; c < 3; c++) begin
      d[c] = 34'(pr.p[3+c]) - 34'(pr.p[c]);
      mag[c] = d[c] < 0 ? 64'(-d[c]) : 64'(d[c]);
      r2w += 66'(mag[c] * mag[c]);
      comp[c] = 0;
    end
    r2 = r2w[65:64] != 0 ? '1 : r2w[63:0];
    if (r2 == 0) begin
      r.coincident = 1'b1;
    end else if (r2 < (cut_sq << wpf_pkg::FRAC_BITS)) begin
      big = 0; eo = 0; fsat = 0; f = 0; sat = 0; any = 0;
      q = div_q32(sig_sq << wpf_pkg::FRAC_BITS, r2, big);
      q2 = mul_q32(q, q, big);
      s = mul_q32(q2, q, big);
      s2 = mul_q32(s, s, big);
      if (s2 > 64'h7FFF_FFFF_FFFF_FFFF) begin
        big = 1; t = '1;
      end else begin
        t = s2 << 1;
      end
      if (big) begin
        m = '1; neg = 1;
      end else begin
        neg = t > s; m = neg ? t - s : s - t;
      end
      e = div_q32(eps24 << wpf_pkg::FRAC_BITS, r2, eo);
      if (m == 0 || e == 0) f = 0;
      else if (eo || big) fsat = 1;
      else f = mul_q32(e, m, fsat);
      for (int c = 0; c < 3; c++) begin
        nc = (d[c] < 0) != neg;
        lim = nc ? 64'h8000_0000 : 64'h7FFF_FFFF;
        po = 0;
        if (mag[c] != 0) begin
          if (fsat) begin
            p = lim; sat = 1;
          end else begin
            p = mul_q32(mag[c], f, po);
            if (po || p > lim) begin
              p = lim; sat = 1;
            end
          end
          if (p != 0) any = 1;
          comp[c] = nc ? (64'd0 - p) : p;
        end
      end
      r.in_range = any;
      r.saturated = sat;
    end
    r.force_x = comp[0][31:0];
    r.force_y = comp[1][31:0];
    r.force_z = comp[2][31:0];
    return r;
  endfunction

  // Register write, only with the pipeline drained; caller drops valid after the last one
  task automatic write_reg(input wpf_pkg::cfg_reg_e idx, input logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      wpf_pkg::CFG_SIGMA_SQUARE:  sig_sq = 64'(val);
      wpf_pkg::CFG_CUTOFF_SQUARE: cut_sq = 64'(val);
      wpf_pkg::CFG_EPSILON_X24:   eps24 = 64'(val);
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Sender goes idle and waits for every outstanding result
  task automatic drain();
    pair_if.valid <= 1'b0;
    while (force_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  // Send one pair beat; optional typed-in result instead of prediction
  task automatic send_pair(input pair_t pr, input logic known, input wpf_pkg::wpf_res_t kres);
    while ($urandom_range(99) < send_idle_pct) begin
      pair_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pair_if.valid <= 1'b1;
    pair_if.first_index <= pr.fi;
    pair_if.second_index <= pr.si;
    pair_if.first_x <= pr.p[0];
    pair_if.first_y <= pr.p[1];
    pair_if.first_z <= pr.p[2];
    pair_if.second_x <= pr.p[3];
    pair_if.second_y <= pr.p[4];
    pair_if.second_z <= pr.p[5];
    do @(posedge clk_i); while (!pair_if.ready);
    force_q.push_back(known ? kres : pair_force(pr));
    @(negedge clk_i);
  endtask

  function automatic pair_t rand_pair(input int mode);
    pair_t pr;
    logic signed [31:0] off;
    pr.fi = 12'($urandom);
    pr.si = 12'($urandom);
    for (int c = 0; c < 3; c++) begin
      pr.p[c] = $urandom;
      case (mode)
        0: off = $signed($urandom_range(131072)) - 65536;      // within about one sigma
        1: off = $signed($urandom_range(8192)) - 4096;         // very close, strong repulsion
        2: off = 0;
        default: off = $urandom;                               // anywhere
      endcase
      pr.p[3+c] = pr.p[c] + off;
    end
    if (mode == 2) pr.p[3 + $urandom_range(2)] += $signed($urandom_range(4)) - 2;
    return pr;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    wpf_pkg::wpf_res_t got, exp_r;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.out_first_index  = res_if.out_first_index;
      got.out_second_index = res_if.out_second_index;
      got.force_x = res_if.force_x;
      got.force_y = res_if.force_y;
      got.force_z = res_if.force_z;
      got.in_range = res_if.in_range;
      got.saturated = res_if.saturated;
      got.coincident = res_if.coincident;
      if (force_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %p", $time, got);
      end else begin
        exp_r = force_q.pop_front();
        if (got !== exp_r) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
        end
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) res_if.ready <= ($urandom_range(99) >= recv_stall_pct);

  initial begin
    row_t    rows [$];
    row_t    rw;
    pair_t   pr;
    int      sets [4][3];
    int      n;
    pair_if.valid = 0;
    pair_if.first_index = 0;
    pair_if.second_index = 0;
    pair_if.first_x = 0; pair_if.first_y = 0; pair_if.first_z = 0;
    pair_if.second_x = 0; pair_if.second_y = 0; pair_if.second_z = 0;
    res_if.ready = 1;
    cfg_if.valid = 0;
    cfg_if.index = wpf_pkg::CFG_SIGMA_SQUARE;
    cfg_if.data = 0;
    sig_sq = 64'(wpf_pkg::SIGMA_RESET);
    cut_sq = 64'(wpf_pkg::CUTOFF_RESET);
    eps24 = 64'(wpf_pkg::EPS_RESET);
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table, reset registers
    for (int k = 0; k < 18; k++) begin
      rw.known = 0;
      rw.res = '0;
      rw.pr.fi = 12'(k);
      rw.pr.si = 12'(12'hFFF - k);
      for (int c = 0; c < 6; c++) rw.pr.p[c] = 0;
      case (k)
        0: begin  // coincident at origin
          rw.known = 1; rw.res.coincident = 1;
        end
        1: begin  // coincident at extremes, full index range
          rw.pr.fi = 12'hFFF; rw.pr.si = 0;
          for (int c = 0; c < 6; c++) rw.pr.p[c] = 32'sh8000_0000;
          rw.known = 1; rw.res.coincident = 1;
        end
        2: begin  // opposite corners, far out of range
          for (int c = 0; c < 3; c++) begin
            rw.pr.p[c] = 32'sh8000_0000; rw.pr.p[3+c] = 32'sh7FFF_FFFF;
          end
          rw.known = 1;
        end
        3: begin
          for (int c = 0; c < 3; c++) begin
            rw.pr.p[c] = 32'sh7FFF_FFFF; rw.pr.p[3+c] = 32'sh8000_0000;
          end
          rw.known = 1;
        end
        4: rw.pr.p[3] = 32'sh0001_0000;           // at sigma, repulsion side
        5: rw.pr.p[4] = -32'sh0000_8000;          // repulsion
        6: rw.pr.p[5] = 32'sh0000_0001;           // huge repulsion, saturating
        7: begin rw.pr.p[3] = 1; rw.pr.p[4] = -1; rw.pr.p[5] = 1; end
        8: rw.pr.p[3] = 32'sh0001_2000;           // just outside cutoff
        9: begin rw.pr.p[3] = 32'sh0001_2100; rw.known = 1; end  // just outside
        10: begin rw.pr.p[0] = 32'sh0000_F000; rw.pr.p[4] = 32'sh0000_0100; end
        11: begin rw.pr.p[2] = 32'sh7FFF_0000; rw.pr.p[5] = 32'sh7FFF_E000; end
        12: begin rw.pr.p[1] = -32'sh0000_FFFF; rw.pr.p[4] = 32'sh0000_0001; end
        13: begin rw.pr.p[3] = 32'sh0000_C000; rw.pr.p[4] = 32'sh0000_2000; end
        14: begin rw.pr.p[0] = 32'sh0000_0800; rw.pr.p[5] = -32'sh0000_0800; end
        15: rw.pr.p[3] = 32'sh0001_1F00;          // weak repulsion, tiny force
        16: begin rw.pr.p[3] = 32'sh0000_E000; rw.pr.p[5] = 32'sh0000_3000; end
        default: rw.pr.p[4] = 32'sh0001_0B00;
      endcase
      if (rw.known) begin
        rw.res.out_first_index = rw.pr.fi;
        rw.res.out_second_index = rw.pr.si;
      end
      rows.push_back(rw);
    end
    foreach (rows[i]) send_pair(rows[i].pr, rows[i].known, rows[i].res);
    drain();

    // Register settings per phase: sigma, cutoff, eps; extremes among them
    sets[0] = '{32'h0001_0000, 32'h0001_428A, 32'h0018_0000};
    sets[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    sets[2] = '{32'h0000_0000, 32'h0004_0000, 32'h0000_0000};
    sets[3] = '{32'h0000_4000, 32'h0000_5000, 32'h0000_0001};

    // Random phases: each idle pattern paired with one register setting, run twice
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      write_reg(wpf_pkg::CFG_SIGMA_SQUARE, sets[ph % 4][0]);
      write_reg(wpf_pkg::CFG_CUTOFF_SQUARE, sets[ph % 4][1]);
      write_reg(wpf_pkg::CFG_EPSILON_X24, sets[ph % 4][2]);
      cfg_if.valid <= 1'b0;
      n = 154;
      for (int i = 0; i < n; i++) begin
        pr = rand_pair($urandom_range(9) < 5 ? 0 : $urandom_range(3));
        send_pair(pr, 1'b0, '0);
        // sender also waits for the line to empty midway through each phase
        if (i == n / 2) drain();
      end
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/wpf_pkg.sv
rtl/wpf_ifs.sv
rtl/wpf_div.sv
rtl/wpf_mulq.sv
rtl/wca_pair_force_core.sv
rtl/wpf_chk.sv
tb/sv/tb.sv
